// ===== hdl/cct_pkg.sv =====
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types and constants for the calibrated cycle-counter timebase.
// ----------------------------------------------------------------------------
package cct_pkg;

    localparam int DATA_W = 64;
    localparam int HALF_W = 32;

    // operation codes
    localparam logic [1:0] OP_CAL_START = 2'd0;
    localparam logic [1:0] OP_CAL_END   = 2'd1;
    localparam logic [1:0] OP_READ      = 2'd2;
    localparam logic [1:0] OP_RESERVED  = 2'd3;

    // status codes
    localparam logic [2:0] ST_VALID      = 3'd0;
    localparam logic [2:0] ST_CALIBRATED = 3'd1;
    localparam logic [2:0] ST_IGNORED    = 3'd2;
    localparam logic [2:0] ST_UNCAL      = 3'd3;
    localparam logic [2:0] ST_ZERO_RATE  = 3'd4;

    // configuration register indexes
    localparam int         CFG_INDEX_W = 1;
    localparam int         CFG_DATA_W  = 32;
    localparam logic [0:0] CFG_REF_CLK = 1'd0;
    localparam logic [0:0] CFG_WINDOW  = 1'd1;

    localparam logic [31:0] REF_CLK_RESET = 32'd1193182;
    localparam logic [15:0] WINDOW_RESET  = 16'd59659;

    localparam logic [63:0] NS_PER_S  = 64'd1000000000;
    localparam logic [63:0] NS_PER_US = 64'd1000;
    localparam logic [63:0] NS_PER_MS = 64'd1000000;

    // time unit divides as q = ((n >> pre) * recip) >> shift, exact for 64-bit n
    localparam int          US_PRESHIFT = 3;
    localparam int          US_SHIFT    = 68;
    localparam logic [63:0] US_RECIP    = 64'd2361183241434822607;
    localparam int          MS_PRESHIFT = 6;
    localparam int          MS_SHIFT    = 72;
    localparam logic [63:0] MS_RECIP    = 64'd302231454903657294;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] stamp;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] nanoseconds;
        logic [63:0] microseconds;
        logic [63:0] milliseconds;
        logic [63:0] rate_out;
    } t_out_item;

endpackage

// ===== hdl/cct_mul.sv =====
// ----------------------------------------------------------------------------
// cct_mul
// Registered 32x32 unsigned multiplier, shared for all partial products.
// ----------------------------------------------------------------------------
module cct_mul (
    input  logic                                  i_clk,
    input  logic [cct_pkg::HALF_W-1:0]            i_a,
    input  logic [cct_pkg::HALF_W-1:0]            i_b,
    output logic [2*cct_pkg::HALF_W-1:0]          o_prod
);

    logic [2*cct_pkg::HALF_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== hdl/cct_div.sv =====
// ----------------------------------------------------------------------------
// cct_div
// Restoring bit-serial 64-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cct_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cct_pkg::DATA_W-1:0]  i_dividend,
    input  logic [cct_pkg::DATA_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [cct_pkg::DATA_W-1:0]  o_quotient
);

    localparam int              CNT_W = $clog2(cct_pkg::DATA_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(cct_pkg::DATA_W - 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [cct_pkg::DATA_W-1:0]  r_quo;
    logic [cct_pkg::DATA_W-1:0]  r_rem;
    logic [cct_pkg::DATA_W-1:0]  r_den;

    logic [cct_pkg::DATA_W:0]    w_trial;
    logic [cct_pkg::DATA_W:0]    w_diff;
    logic                        w_fits;

    always_comb begin
        w_trial = {r_rem, r_quo[cct_pkg::DATA_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_fits  = (w_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == LAST);
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_fits ? w_diff[cct_pkg::DATA_W-1:0] : w_trial[cct_pkg::DATA_W-1:0];
                r_quo <= {r_quo[cct_pkg::DATA_W-2:0], w_fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hdl/cycle_counter_calibrated_timebase_top.sv =====
// ----------------------------------------------------------------------------
// cycle_counter_calibrated_timebase_top
// Cycle-counter timebase calibrated against a reference timer window.
// ----------------------------------------------------------------------------
// Usage: an input item carries an operation and a cycle-counter stamp. A
// calibration start latches the stamp; a calibration end turns the elapsed
// cycles into a cycle rate and a nanosecond multiplier; a read returns the
// time since the base in ns, us and ms. Every item gives exactly one result.
// Input accepted when i_in_valid is high and o_in_stall is low; the result
// leaves when o_out_valid is high and i_out_stall is low. o_in_stall is high
// while an item is being worked on, so items are taken one at a time.
// Start, reserved code and answered-at-once cases go straight to the done
// state and then into the output register. A calibration end forms 4
// partial products on the shared 32x32 multiplier, then runs two 64-bit
// divides on the bit-serial divider, for the rate and then the multiplier;
// only the first if the rate comes out zero. A read forms three products on
// the shared multiplier, for ns and then reciprocal products for us and ms.
// The next item can be taken in the same cycle as the result appears.
// The output register holds one result; a stalled receiver holds it and the
// next finished item waits in the done state until the register frees up.
// Reset (synchronous, active low) clears calibration state and loads the
// reference clock and window registers with their defaults.
// ----------------------------------------------------------------------------
module cycle_counter_calibrated_timebase_top #(
    parameter int FRACTION_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  cct_pkg::t_in_item                    i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output cct_pkg::t_out_item                   o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [cct_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [cct_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);

    localparam logic [63:0] MULT_NUM = cct_pkg::NS_PER_S << FRACTION_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_ISSUE,
        S_MUL_ACC,
        S_DIV_RATE,
        S_DIV_MULT,
        S_DONE
    } t_state;

    // which product the multiply pass is forming
    typedef enum logic [1:0] {
        P_RATE,
        P_NS,
        P_US,
        P_MS
    } t_pass;

    t_state r_state;
    t_pass  r_pass;

    // configuration
    logic [31:0] r_ref_clk;
    logic [15:0] r_window;

    // calibration state
    logic [63:0] r_start_stamp;
    logic [63:0] r_base_stamp;
    logic [63:0] r_cycle_rate;
    logic [63:0] r_ns_mult;

    // working registers
    logic [1:0]  r_cnt;
    logic [63:0] r_opa;
    logic [63:0] r_opb;
    logic [127:0] r_acc;
    logic [63:0] r_end_stamp;
    logic [63:0] r_new_rate;
    logic [2:0]  r_status;
    logic [63:0] r_ns;
    logic [63:0] r_us;
    logic [63:0] r_ms;

    logic        r_div_start;
    logic [63:0] r_div_a;
    logic [63:0] r_div_b;

    logic        r_out_valid;
    cct_pkg::t_out_item r_out;

    logic [31:0]  w_mul_a;
    logic [31:0]  w_mul_b;
    logic [63:0]  w_prod;
    logic [6:0]   w_shift;
    logic [127:0] w_acc_sum;
    logic [63:0]  w_ns;
    logic         w_div_done;
    logic [63:0]  w_quo;
    logic         w_accept;
    logic         w_out_free;
    logic         w_out_load;
    logic         w_div_go;

    // partial product k: a half from bit 0, b half from bit 1
    always_comb begin
        w_mul_a   = r_cnt[0] ? r_opa[63:32] : r_opa[31:0];
        w_mul_b   = r_cnt[1] ? r_opb[63:32] : r_opb[31:0];
        w_shift   = {({1'b0, r_cnt[0]} + {1'b0, r_cnt[1]}), 5'b0};
        w_acc_sum = r_acc + ({64'b0, w_prod} << w_shift);
        w_ns      = w_acc_sum[FRACTION_BITS +: 64];
        w_accept  = i_in_valid && (r_state == S_IDLE);
        w_out_free = !r_out_valid || !i_out_stall;
        w_out_load = (r_state == S_DONE) && w_out_free;
        w_div_go   = ((r_state == S_MUL_ACC) && (r_cnt == 2'd3) && (r_pass == P_RATE))
                  || ((r_state == S_DIV_RATE) && w_div_done && (w_quo != '0));
    end

    cct_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    cct_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_a),
        .i_divisor  (r_div_b),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_clk <= cct_pkg::REF_CLK_RESET;
            r_window  <= cct_pkg::WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cct_pkg::CFG_REF_CLK: r_ref_clk <= i_cfg_wdata;
                cct_pkg::CFG_WINDOW:  r_window  <= i_cfg_wdata[15:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_start_stamp <= '0;
            r_base_stamp  <= '0;
            r_cycle_rate  <= '0;
            r_ns_mult     <= '0;
            r_div_start   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_div_start <= w_div_go;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_ns  <= '0;
                        r_us  <= '0;
                        r_ms  <= '0;
                        r_cnt <= '0;
                        r_acc <= '0;
                        unique case (i_in_data.operation) inside
                            cct_pkg::OP_CAL_END: begin
                                r_pass      <= P_RATE;
                                r_opa       <= i_in_data.stamp - r_start_stamp;
                                r_opb       <= {32'b0, r_ref_clk};
                                r_end_stamp <= i_in_data.stamp;
                                if (r_cycle_rate != '0) begin
                                    r_status <= cct_pkg::ST_IGNORED;
                                    r_state  <= S_DONE;
                                end else if (r_window == '0) begin
                                    r_status <= cct_pkg::ST_ZERO_RATE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_MUL_ISSUE;
                                end
                            end
                            cct_pkg::OP_READ: begin
                                r_pass    <= P_NS;
                                r_opa     <= i_in_data.stamp - r_base_stamp;
                                r_opb     <= r_ns_mult;
                                if (r_ns_mult == '0) begin
                                    r_status <= cct_pkg::ST_UNCAL;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_MUL_ISSUE;
                                end
                            end
                            cct_pkg::OP_CAL_START, cct_pkg::OP_RESERVED: begin
                                if (i_in_data.operation == cct_pkg::OP_CAL_START) begin
                                    r_start_stamp <= i_in_data.stamp;
                                end
                                r_status <= (r_cycle_rate != '0) ? cct_pkg::ST_CALIBRATED
                                                                 : cct_pkg::ST_UNCAL;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_MUL_ISSUE: begin
                    r_state <= S_MUL_ACC;
                end
                S_MUL_ACC: begin
                    // counter wraps to zero after the fourth partial product
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 2'd3) begin
                        r_acc <= '0;
                        unique case (r_pass)
                            P_RATE: begin
                                // product wraps at 64 bits
                                r_div_a <= w_acc_sum[63:0];
                                r_div_b <= {48'b0, r_window};
                                r_state <= S_DIV_RATE;
                            end
                            P_NS: begin
                                r_ns    <= w_ns;
                                r_opa   <= w_ns >> cct_pkg::US_PRESHIFT;
                                r_opb   <= cct_pkg::US_RECIP;
                                r_pass  <= P_US;
                                r_state <= S_MUL_ISSUE;
                            end
                            P_US: begin
                                r_us    <= 64'(w_acc_sum >> cct_pkg::US_SHIFT);
                                r_opa   <= r_ns >> cct_pkg::MS_PRESHIFT;
                                r_opb   <= cct_pkg::MS_RECIP;
                                r_pass  <= P_MS;
                                r_state <= S_MUL_ISSUE;
                            end
                            P_MS: begin
                                r_ms     <= 64'(w_acc_sum >> cct_pkg::MS_SHIFT);
                                r_status <= cct_pkg::ST_VALID;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end else begin
                        r_acc   <= w_acc_sum;
                        r_state <= S_MUL_ISSUE;
                    end
                end
                S_DIV_RATE: begin
                    if (w_div_done) begin
                        if (w_quo == '0) begin
                            r_status <= cct_pkg::ST_ZERO_RATE;
                            r_state  <= S_DONE;
                        end else begin
                            r_new_rate  <= w_quo;
                            r_div_a     <= MULT_NUM;
                            r_div_b     <= w_quo;
                            r_state     <= S_DIV_MULT;
                        end
                    end
                end
                S_DIV_MULT: begin
                    if (w_div_done) begin
                        r_cycle_rate <= r_new_rate;
                        r_base_stamp <= r_end_stamp;
                        r_ns_mult    <= w_quo;
                        r_status     <= cct_pkg::ST_CALIBRATED;
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out.status       <= r_status;
                        r_out.nanoseconds  <= r_ns;
                        r_out.microseconds <= r_us;
                        r_out.milliseconds <= r_ms;
                        r_out.rate_out     <= r_cycle_rate;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
